### hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge, held off while reset is asserted.
`define FUD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define FUD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define FUD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define FUD_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

### hw/rtl/fud_pkg.sv
// Types and constants shared by the form-encoded string decoder.
`timescale 1ns / 1ps
`default_nettype none

package fud_pkg;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters with a meaning in the encoding.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;

  // Error codes carried on the result channel.
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX = 2'd1;
  localparam logic [1:0] ERR_IN_KEY  = 2'd2;

  // Escape tracking codes.
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_valid;
    logic       in_value;
    logic       field_end;
    logic [1:0] error_code;
    logic       last_result;
  } fud_result_t;

  // One queue entry: the results caused by one input byte.
  typedef struct packed {
    fud_result_t first;
    fud_result_t second;
    logic        two;
  } fud_entry_t;

  // Queue write side, front to queue.
  typedef struct packed {
    logic       push;
    fud_entry_t entry;
  } fud_qwr_t;

  // Queue read side, queue to back.
  typedef struct packed {
    logic       not_empty;
    fud_entry_t head;
  } fud_qrd_t;

endpackage

`default_nettype wire

### hw/rtl/fud_if.sv
// Stream interfaces for raw input bytes and decoded results.
`timescale 1ns / 1ps
`default_nettype none

interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       char_valid;
  logic       in_value;
  logic       field_end;
  logic [1:0] error_code;
  logic       last_result;

  modport source (output valid, output out_byte, output char_valid, output in_value,
                  output field_end, output error_code, output last_result, input ready);
  modport sink   (input valid, input out_byte, input char_valid, input in_value,
                  input field_end, input error_code, input last_result, output ready);
endinterface

`default_nettype wire

### hw/rtl/fud_front.sv
// Front end: accepts raw bytes, tracks key/value and escape state, builds results.
`timescale 1ns / 1ps
`default_nettype none

module fud_front (
  input  wire           clk,
  input  wire           rst_n,
  fud_in_if.sink        in_ch,
  input  wire           q_space,
  output fud_pkg::fud_qwr_t q_wr
);

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one hex digit in either case.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c inside {[fud_pkg::CH_ZERO:fud_pkg::CH_NINE]}) begin
      d = c - fud_pkg::CH_ZERO;
      h.ok = 1'b1;
    end else if (c inside {[fud_pkg::CH_LC_A:fud_pkg::CH_LC_F]}) begin
      d = c - fud_pkg::CH_LC_A + 8'd10;
      h.ok = 1'b1;
    end else if (c inside {[fud_pkg::CH_UC_A:fud_pkg::CH_UC_F]}) begin
      d = c - fud_pkg::CH_UC_A + 8'd10;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  logic       value_phase_r, value_phase_nxt;
  logic [1:0] escape_stage_r, escape_stage_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;

  logic                accept;
  hex_t                hx;
  logic                key_open;
  logic                x_vld, f_vld;
  fud_pkg::fud_result_t x_res, f_res;

  assign in_ch.ready = q_space;
  assign accept      = in_ch.valid && q_space;
  assign hx          = hex_decode(in_ch.in_byte);

  // Per-byte decode: the byte's own result first, then any end-of-string result.
  always_comb begin
    value_phase_nxt  = value_phase_r;
    escape_stage_nxt = escape_stage_r;
    high_nibble_nxt  = high_nibble_r;
    key_open         = !value_phase_r;
    x_vld            = 1'b0;
    x_res            = '0;
    f_vld            = 1'b0;
    f_res            = '0;
    x_res.in_value   = value_phase_r;

    if (escape_stage_r == fud_pkg::ESC_FIRST || escape_stage_r == fud_pkg::ESC_SECOND) begin
      if (!hx.ok) begin
        x_vld            = 1'b1;
        x_res.error_code = fud_pkg::ERR_BAD_HEX;
        escape_stage_nxt = fud_pkg::ESC_NONE;
      end else if (escape_stage_r == fud_pkg::ESC_FIRST) begin
        high_nibble_nxt  = hx.val;
        escape_stage_nxt = fud_pkg::ESC_SECOND;
      end else begin
        x_vld            = 1'b1;
        x_res.out_byte   = {high_nibble_r, hx.val};
        x_res.char_valid = 1'b1;
        escape_stage_nxt = fud_pkg::ESC_NONE;
      end
    end else begin
      escape_stage_nxt = fud_pkg::ESC_NONE;
      if (in_ch.in_byte == fud_pkg::CH_PERCENT) begin
        escape_stage_nxt = fud_pkg::ESC_FIRST;
        high_nibble_nxt  = '0;
      end else if (in_ch.in_byte == fud_pkg::CH_PLUS) begin
        x_vld            = 1'b1;
        x_res.out_byte   = fud_pkg::CH_SPACE;
        x_res.char_valid = 1'b1;
      end else if (!value_phase_r && in_ch.in_byte == fud_pkg::CH_EQUALS) begin
        x_vld           = 1'b1;
        x_res.field_end = 1'b1;
        value_phase_nxt = 1'b1;
        key_open        = 1'b0;
      end else if (value_phase_r && in_ch.in_byte == fud_pkg::CH_AMP) begin
        x_vld           = 1'b1;
        x_res.field_end = 1'b1;
        value_phase_nxt = 1'b0;
      end else begin
        x_vld            = 1'b1;
        x_res.out_byte   = in_ch.in_byte;
        x_res.char_valid = 1'b1;
      end
    end

    // Final byte: flush a pending escape, then close the value or flag an open key.
    if (in_ch.last_byte) begin
      if (escape_stage_nxt == fud_pkg::ESC_FIRST || escape_stage_nxt == fud_pkg::ESC_SECOND) begin
        x_vld            = 1'b1;
        x_res            = '0;
        x_res.in_value   = value_phase_nxt;
        x_res.char_valid = 1'b1;
        x_res.out_byte   = (escape_stage_nxt == fud_pkg::ESC_SECOND) ?
                           {high_nibble_nxt, 4'h0} : 8'h00;
      end
      if (value_phase_nxt) begin
        f_vld           = 1'b1;
        f_res.in_value  = 1'b1;
        f_res.field_end = 1'b1;
      end else if (key_open) begin
        f_vld            = 1'b1;
        f_res.error_code = fud_pkg::ERR_IN_KEY;
      end
      value_phase_nxt  = 1'b0;
      escape_stage_nxt = fud_pkg::ESC_NONE;
      high_nibble_nxt  = '0;
    end
  end

  // Pack the results of this byte into one queue entry.
  always_comb begin
    q_wr                         = '0;
    q_wr.push                    = accept && (x_vld || f_vld);
    q_wr.entry.two               = x_vld && f_vld;
    q_wr.entry.first             = x_vld ? x_res : f_res;
    q_wr.entry.first.last_result = !(x_vld && f_vld);
    q_wr.entry.second            = f_res;
    q_wr.entry.second.last_result = 1'b1;
  end

  // Parser state advances on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_phase_r  <= 1'b0;
      escape_stage_r <= fud_pkg::ESC_NONE;
      high_nibble_r  <= '0;
    end else if (accept) begin
      value_phase_r  <= value_phase_nxt;
      escape_stage_r <= escape_stage_nxt;
      high_nibble_r  <= high_nibble_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fud_queue.sv
// Short queue of result entries between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fud_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire fud_pkg::fud_qwr_t q_wr,
  input  wire                    pop,
  output logic                   q_space,
  output fud_pkg::fud_qrd_t      q_rd
);

  fud_pkg::fud_entry_t mem [fud_pkg::QDEPTH];

  logic [fud_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fud_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fud_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign q_space        = count_r < fud_pkg::QCNT_W'(fud_pkg::QDEPTH);
  assign q_rd.not_empty = count_r != '0;
  assign q_rd.head      = mem[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == fud_pkg::QPTR_W'(fud_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == fud_pkg::QPTR_W'(fud_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + fud_pkg::QCNT_W'(q_wr.push) - fud_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr_r] <= q_wr.entry;
    end
  end

  `FUD_ASSERT(a_no_overflow, clk, rst_n, q_wr.push |-> q_space, "push into a full queue")
  `FUD_ASSERT(a_no_underflow, clk, rst_n, pop |-> q_rd.not_empty, "pop from an empty queue")
  `FUD_ASSERT(a_count_bound, clk, rst_n, count_r <= fud_pkg::QCNT_W'(fud_pkg::QDEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

### hw/rtl/fud_back.sv
// Back end: drives queued results onto the output channel, one per transfer.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fud_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire fud_pkg::fud_qrd_t q_rd,
  output logic                   pop,
  fud_out_if.source              out_ch
);

  // Set while the second result of the head entry is on offer.
  logic sel_r, sel_nxt;
  logic xfer;

  fud_pkg::fud_result_t cur;

  assign cur  = sel_r ? q_rd.head.second : q_rd.head.first;
  assign xfer = q_rd.not_empty && out_ch.ready;
  assign pop  = xfer && (sel_r || !q_rd.head.two);

  assign out_ch.valid       = q_rd.not_empty;
  assign out_ch.out_byte    = cur.out_byte;
  assign out_ch.char_valid  = cur.char_valid;
  assign out_ch.in_value    = cur.in_value;
  assign out_ch.field_end   = cur.field_end;
  assign out_ch.error_code  = cur.error_code;
  assign out_ch.last_result = cur.last_result;

  // Step to the second result, or back to the first once the entry leaves.
  always_comb begin
    sel_nxt = sel_r;
    if (xfer) begin
      sel_nxt = !sel_r && q_rd.head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  `FUD_ASSERT(a_sel_needs_pair, clk, rst_n, sel_r |-> (q_rd.not_empty && q_rd.head.two), "second slot selected without a pair")
  `FUD_ASSERT(a_last_on_pop, clk, rst_n, pop |-> out_ch.last_result, "entry retired before its last result")

endmodule

`default_nettype wire

### hw/rtl/form_urlencoded_decoder_unit.sv
// Top level of the form-encoded query string decoder.
// Accepts one raw byte per cycle while the queue has space and gives decoded characters,
// field-end markers and error codes on the result channel, one result per cycle while
// the receiver is ready. A byte causes zero, one or two results; two only arise on the
// final byte of a string, when the byte's own result (a character, flushed escape,
// field-end marker or bad-hex error) is followed by the close of a value or a key
// error, and those take two output transfers. Input and output are parted by a two-entry
// queue, so in_ch.ready depends only on queue occupancy and a sustained rate of one byte
// per cycle holds while the result side keeps up; results are registered in the queue.
`timescale 1ns / 1ps
`default_nettype none

module form_urlencoded_decoder_unit (
  input  wire       clk,
  input  wire       rst_n,
  fud_in_if.sink    in_ch,
  fud_out_if.source out_ch
);

  fud_pkg::fud_qwr_t q_wr;
  fud_pkg::fud_qrd_t q_rd;
  logic              q_space;
  logic              pop;

  // Parsing and result building.
  fud_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_space (q_space),
    .q_wr    (q_wr)
  );

  // Decoupling queue.
  fud_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .pop     (pop),
    .q_space (q_space),
    .q_rd    (q_rd)
  );

  // Result delivery.
  fud_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### test/tb_form_urlencoded_decoder_unit.sv
// Self-checking testbench for the form-encoded query string decoder.
`timescale 1ns / 1ps

module tb_form_urlencoded_decoder_unit;

  // Cycles with no transfer on either side before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed after the last result before the verdict.
  localparam int DRAIN_CYCLES = 8;
  // Length of the long receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  fud_in_if  in_ch ();
  fud_out_if out_ch ();

  form_urlencoded_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder state as tracked by the testbench.
  logic       dec_value_phase;
  logic [1:0] dec_escape;
  logic [3:0] dec_high_nibble;

  fud_pkg::fud_result_t due_results[$];
  logic [7:0]           query_bytes[$];

  int  failures;
  int  bytes_sent;
  int  quiet_cycles;
  int  results_hold;
  bit  gaps_on;
  bit  stalls_on;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Value of a hex digit, or -1 when the byte is not one.
  function automatic int hex_value(input logic [7:0] c);
    if (c >= fud_pkg::CH_ZERO && c <= fud_pkg::CH_NINE)
      return int'(c - fud_pkg::CH_ZERO);
    if (c >= fud_pkg::CH_LC_A && c <= fud_pkg::CH_LC_F)
      return int'(c - fud_pkg::CH_LC_A) + 10;
    if (c >= fud_pkg::CH_UC_A && c <= fud_pkg::CH_UC_F)
      return int'(c - fud_pkg::CH_UC_A) + 10;
    return -1;
  endfunction

  function automatic fud_pkg::fud_result_t make_result(input logic [7:0] ch,
                                                       input logic ch_valid,
                                                       input logic phase, input logic fend,
                                                       input logic [1:0] err);
    fud_pkg::fud_result_t r;
    r.out_byte    = ch;
    r.char_valid  = ch_valid;
    r.in_value    = phase;
    r.field_end   = fend;
    r.error_code  = err;
    r.last_result = 1'b0;
    return r;
  endfunction

  // Works out the results that one accepted byte causes and queues them in order.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    fud_pkg::fud_result_t caused[$];
    fud_pkg::fud_result_t r;
    logic                 phase;
    logic                 key_open;
    int                   digit;
    phase    = dec_value_phase;
    key_open = !phase;
    digit    = hex_value(b);
    if (dec_escape == fud_pkg::ESC_FIRST || dec_escape == fud_pkg::ESC_SECOND) begin
      if (digit < 0) begin
        caused.push_back(make_result(8'h00, 1'b0, phase, 1'b0, fud_pkg::ERR_BAD_HEX));
        dec_escape = fud_pkg::ESC_NONE;
      end else if (dec_escape == fud_pkg::ESC_FIRST) begin
        dec_high_nibble = digit[3:0];
        dec_escape      = fud_pkg::ESC_SECOND;
      end else begin
        caused.push_back(make_result({dec_high_nibble, digit[3:0]}, 1'b1, phase, 1'b0,
                                     fud_pkg::ERR_OK));
        dec_escape = fud_pkg::ESC_NONE;
      end
    end else if (b == fud_pkg::CH_PERCENT) begin
      dec_escape      = fud_pkg::ESC_FIRST;
      dec_high_nibble = 4'h0;
    end else if (b == fud_pkg::CH_PLUS) begin
      caused.push_back(make_result(fud_pkg::CH_SPACE, 1'b1, phase, 1'b0, fud_pkg::ERR_OK));
    end else if (!phase && b == fud_pkg::CH_EQUALS) begin
      caused.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, fud_pkg::ERR_OK));
      dec_value_phase = 1'b1;
      key_open        = 1'b0;
    end else if (phase && b == fud_pkg::CH_AMP) begin
      caused.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, fud_pkg::ERR_OK));
      dec_value_phase = 1'b0;
    end else begin
      caused.push_back(make_result(b, 1'b1, phase, 1'b0, fud_pkg::ERR_OK));
    end

    // The final byte flushes a pending escape and closes the value, or flags an open key.
    if (last) begin
      phase = dec_value_phase;
      if (dec_escape == fud_pkg::ESC_FIRST)
        caused.push_back(make_result(8'h00, 1'b1, phase, 1'b0, fud_pkg::ERR_OK));
      else if (dec_escape == fud_pkg::ESC_SECOND)
        caused.push_back(make_result({dec_high_nibble, 4'h0}, 1'b1, phase, 1'b0,
                                     fud_pkg::ERR_OK));
      if (phase)
        caused.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, fud_pkg::ERR_OK));
      else if (key_open)
        caused.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b0, fud_pkg::ERR_IN_KEY));
      dec_value_phase = 1'b0;
      dec_escape      = fud_pkg::ESC_NONE;
      dec_high_nibble = 4'h0;
    end

    foreach (caused[i]) begin
      r             = caused[i];
      r.last_result = (i == caused.size() - 1);
      due_results.push_back(r);
    end
  endfunction

  // Each input transfer updates the tracked state and queues its results.
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_value_phase <= 1'b0;
      dec_escape      <= fud_pkg::ESC_NONE;
      dec_high_nibble <= 4'h0;
    end else if (in_ch.valid && in_ch.ready) begin
      decode_byte(in_ch.in_byte, in_ch.last_byte);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("Field %s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Each result transfer is compared with the oldest outstanding result.
  always @(posedge clk) begin : result_check
    fud_pkg::fud_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("Result transfer with none outstanding: out_byte %0h, error_code %0d",
               out_ch.out_byte, out_ch.error_code);
        failures++;
      end else begin
        want = due_results.pop_front();
        check_field("out_byte", want.out_byte, out_ch.out_byte);
        check_field("char_valid", want.char_valid, out_ch.char_valid);
        check_field("in_value", want.in_value, out_ch.in_value);
        check_field("field_end", want.field_end, out_ch.field_end);
        check_field("error_code", want.error_code, out_ch.error_code);
        check_field("last_result", want.last_result, out_ch.last_result);
      end
    end
  end

  // The run is abandoned when neither side has made a transfer for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (results_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (results_hold) @(posedge clk);
        results_hold = 0;
        out_ch.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one byte, waits for its transfer, then at random idles for a while if gaps are on.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_query();
    foreach (query_bytes[i])
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return fud_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? fud_pkg::CH_UC_A : fud_pkg::CH_LC_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0: return fud_pkg::CH_LC_A + 8'($urandom_range(0, 25));
      1: return fud_pkg::CH_UC_A + 8'($urandom_range(0, 25));
      default: return fud_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Appends a key or value body: mostly plain text, escapes and spaces, some noise.
  function automatic void append_field(input bit is_value);
    int pick;
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        query_bytes.push_back(plain_char());
      end else if (pick < 58) begin
        query_bytes.push_back(fud_pkg::CH_PLUS);
      end else if (pick < 80) begin
        query_bytes.push_back(fud_pkg::CH_PERCENT);
        query_bytes.push_back(hex_char());
        query_bytes.push_back(hex_char());
      end else if (pick < 87) begin
        // The separator of the other field kind is a literal here.
        query_bytes.push_back(is_value ? fud_pkg::CH_EQUALS : fud_pkg::CH_AMP);
      end else if (pick < 93) begin
        query_bytes.push_back(fud_pkg::CH_PERCENT);
        if ($urandom_range(0, 1)) query_bytes.push_back(hex_char());
        query_bytes.push_back(non_hex_char());
      end else begin
        query_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Builds a query of one to four pairs, sometimes cut short in a key or an escape.
  function automatic void build_query();
    query_bytes.delete();
    for (int i = 0; i < $urandom_range(1, 4); i++) begin
      if (i > 0) query_bytes.push_back(fud_pkg::CH_AMP);
      append_field(1'b0);
      query_bytes.push_back(fud_pkg::CH_EQUALS);
      append_field(1'b1);
    end
    case ($urandom_range(0, 9))
      0: begin
        query_bytes.push_back(fud_pkg::CH_AMP);
        append_field(1'b0);
      end
      1: begin
        query_bytes.push_back(fud_pkg::CH_PERCENT);
        if ($urandom_range(0, 1)) query_bytes.push_back(hex_char());
      end
      2: query_bytes.push_back(fud_pkg::CH_AMP);
      default: ;
    endcase
  endfunction

  // Literal separators, escapes, end of input in every state, extreme byte values.
  task automatic test_special_cases();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_text("&=b=%41+");
    send_text("%Fa%0g");
    send_text("=%");
    send_text("x%4");
    send_text("%z");
    send_byte(8'hFF, 1'b0);
    send_byte(fud_pkg::CH_EQUALS, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(fud_pkg::CH_AMP, 1'b1);
  endtask

  // Random queries, some malformed or cut short, idling switched on and off per query.
  task automatic test_random_queries();
    while (bytes_sent < 700) begin
      gaps_on   = ($urandom_range(0, 4) != 0);
      stalls_on = ($urandom_range(0, 4) != 0);
      build_query();
      send_query();
    end
  endtask

  // Arbitrary bytes with the final-byte flag set at random.
  task automatic test_byte_noise();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (80)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
  endtask

  // The receiver holds off while bytes keep coming, so the input stalls.
  task automatic test_back_pressure();
    int start_count;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    results_hold = HOLD_CYCLES;
    start_count  = bytes_sent;
    while (bytes_sent - start_count < 30) begin
      build_query();
      send_query();
    end
  endtask

  // Reset, the tests in turn, then the drain and the verdict.
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.last_byte <= 1'b0;
    failures     = 0;
    bytes_sent   = 0;
    quiet_cycles = 0;
    results_hold = 0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_random_queries();
    test_byte_noise();
    test_back_pressure();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
